### design/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants for the serial line assembler: character codes,
// event codes, register map and the beat types passed between modules.
// ----------------------------------------------------------------------------
package sla_pkg;

   // line store depth default
   localparam int LINE_CHARS_DEF = 64;

   // field widths
   localparam int RX_W       = 8;
   localparam int CHAR_W     = 7;
   localparam int EVENT_W    = 3;
   localparam int LEN_W      = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_ECHO_ENABLE = 2'd0;
   localparam logic [1:0] REG_SEMI_ENDS   = 2'd1;
   localparam logic [1:0] REG_NL_ADDS_CR  = 2'd2;

   // event codes
   localparam logic [EVENT_W-1:0] EV_STORED      = 3'd0;
   localparam logic [EVENT_W-1:0] EV_ERASED      = 3'd1;
   localparam logic [EVENT_W-1:0] EV_ERASE_EMPTY = 3'd2;
   localparam logic [EVENT_W-1:0] EV_LINE_DONE   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_OVERFLOW    = 3'd4;
   localparam logic [EVENT_W-1:0] EV_KILL        = 3'd5;
   localparam logic [EVENT_W-1:0] EV_PAUSE       = 3'd6;
   localparam logic [EVENT_W-1:0] EV_RESUME      = 3'd7;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL  = 7'd0;
   localparam logic [CHAR_W-1:0] CH_ETX  = 7'd3;
   localparam logic [CHAR_W-1:0] CH_BS   = 7'd8;
   localparam logic [CHAR_W-1:0] CH_LF   = 7'd10;
   localparam logic [CHAR_W-1:0] CH_CR   = 7'd13;
   localparam logic [CHAR_W-1:0] CH_XON  = 7'd17;
   localparam logic [CHAR_W-1:0] CH_XOFF = 7'd19;
   localparam logic [CHAR_W-1:0] CH_CAN  = 7'd24;
   localparam logic [CHAR_W-1:0] CH_ESC  = 7'd27;
   localparam logic [CHAR_W-1:0] CH_SEMI = 7'd59;
   localparam logic [CHAR_W-1:0] CH_DEL  = 7'd127;

   // mode bits from the register file
   typedef struct packed {
      logic echo_enable;
      logic semicolon_ends_line;
      logic newline_adds_cr;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic               echo_valid;
      logic [CHAR_W-1:0]  echo_char;
      logic               echo_cr_follows;
      logic               line_valid;
      logic [CHAR_W-1:0]  line_char;
      logic [LEN_W-1:0]   line_length;
      logic               last;
   } rsp_type;

endpackage

### design/sla_ram.sv
// ----------------------------------------------------------------------------
// sla_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sla_csr.sv
// ----------------------------------------------------------------------------
// sla_csr
// Register file for the three mode bits, written and read over the apb port.
// ----------------------------------------------------------------------------
module sla_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output sla_pkg::cfg_type               cfg
);

   sla_pkg::cfg_type cfg_ff;
   sla_pkg::cfg_type cfg_in;
   logic             wr_beat;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register writes, bit 0 only
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (reg_idx)
            sla_pkg::REG_ECHO_ENABLE: cfg_in.echo_enable         = csr_pwdata[0];
            sla_pkg::REG_SEMI_ENDS:   cfg_in.semicolon_ends_line = csr_pwdata[0];
            sla_pkg::REG_NL_ADDS_CR:  cfg_in.newline_adds_cr     = csr_pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         sla_pkg::REG_ECHO_ENABLE: csr_prdata[0] = cfg_ff.echo_enable;
         sla_pkg::REG_SEMI_ENDS:   csr_prdata[0] = cfg_ff.semicolon_ends_line;
         sla_pkg::REG_NL_ADDS_CR:  csr_prdata[0] = cfg_ff.newline_adds_cr;
         default:                  csr_prdata    = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/sla_core.sv
// ----------------------------------------------------------------------------
// sla_core
// Character classifier and line sequencer around the line store RAM. Stores
// and erases as a byte is taken; a line end replays the store char by char, in a read state then a wait state.
// ----------------------------------------------------------------------------
module sla_core #(
   parameter int LINE_CHARS = sla_pkg::LINE_CHARS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sla_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [sla_pkg::RX_W-1:0]   rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sla_pkg::rsp_type           rsp
);

   localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
   localparam int CW = $clog2(LINE_CHARS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               len_ff, len_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic                        out_vld_ff, out_vld_in;
   sla_pkg::rsp_type            out_ff, out_in;

   logic [sla_pkg::CHAR_W-1:0]  c;
   logic                        slot_free;
   logic                        accept;
   logic                        is_eol, is_erase, is_kill, is_store;
   logic                        full;
   logic                        ram_wr, ram_rd;
   logic [sla_pkg::CHAR_W-1:0]  ram_q;
   logic                        run_last;

   assign c         = rx_byte[sla_pkg::CHAR_W-1:0];
   assign slot_free = !out_vld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(LINE_CHARS));

   // classify the received character
   assign is_eol   = (c == sla_pkg::CH_NUL) || (c == sla_pkg::CH_LF) ||
                     (c == sla_pkg::CH_CR) ||
                     ((c == sla_pkg::CH_SEMI) && cfg.semicolon_ends_line);
   assign is_erase = (c == sla_pkg::CH_BS) || (c == sla_pkg::CH_DEL);
   assign is_kill  = (c == sla_pkg::CH_ETX) || (c == sla_pkg::CH_CAN) ||
                     (c == sla_pkg::CH_ESC);
   assign is_store = !is_eol && !is_erase && !is_kill &&
                     (c != sla_pkg::CH_XON) && (c != sla_pkg::CH_XOFF);

   // line store: written on a stored char, read only while replaying
   assign ram_wr   = accept && is_store && !full;
   assign ram_rd   = (state_ff == ST_READ);
   assign run_last = ((CW'(idx_ff) + CW'(1)) == len_ff);

   sla_ram #(
      .WIDTH (sla_pkg::CHAR_W),
      .DEPTH (LINE_CHARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (c),
      .rd_en   (ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_q)
   );

   // sequencer and result beat
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_in      = '0;
               out_in.last = 1'b1;
               priority if (is_eol) begin
                  count_in = '0;
                  if (count_ff == '0) begin
                     out_in.event_res       = sla_pkg::EV_LINE_DONE;
                     out_in.echo_valid      = cfg.echo_enable;
                     out_in.echo_char       = cfg.echo_enable ? sla_pkg::CH_LF : '0;
                     out_in.echo_cr_follows = cfg.echo_enable && cfg.newline_adds_cr;
                     out_vld_in             = 1'b1;
                  end else begin
                     len_in   = count_ff;
                     idx_in   = '0;
                     state_in = ST_READ;
                  end
               end else if (is_erase) begin
                  if (count_ff != '0) begin
                     count_in           = count_ff - CW'(1);
                     out_in.event_res   = sla_pkg::EV_ERASED;
                     out_in.echo_valid  = cfg.echo_enable;
                     out_in.echo_char   = cfg.echo_enable ? c : '0;
                     out_in.line_length = sla_pkg::LEN_W'(count_ff - CW'(1));
                  end else begin
                     out_in.event_res   = sla_pkg::EV_ERASE_EMPTY;
                  end
                  out_vld_in = 1'b1;
               end else if (is_kill) begin
                  out_in.event_res   = sla_pkg::EV_KILL;
                  out_in.line_length = sla_pkg::LEN_W'(count_ff);
                  out_vld_in         = 1'b1;
               end else if (c == sla_pkg::CH_XON) begin
                  out_in.event_res   = sla_pkg::EV_RESUME;
                  out_in.line_length = sla_pkg::LEN_W'(count_ff);
                  out_vld_in         = 1'b1;
               end else if (c == sla_pkg::CH_XOFF) begin
                  out_in.event_res   = sla_pkg::EV_PAUSE;
                  out_in.line_length = sla_pkg::LEN_W'(count_ff);
                  out_vld_in         = 1'b1;
               end else if (full) begin
                  out_in.event_res   = sla_pkg::EV_OVERFLOW;
                  out_in.line_length = sla_pkg::LEN_W'(count_ff);
                  out_vld_in         = 1'b1;
               end else begin
                  count_in           = count_ff + CW'(1);
                  out_in.event_res   = sla_pkg::EV_STORED;
                  out_in.echo_valid  = cfg.echo_enable;
                  out_in.echo_char   = cfg.echo_enable ? c : '0;
                  out_in.line_length = sla_pkg::LEN_W'(count_ff + CW'(1));
                  out_vld_in         = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // read data is held in the ram output until the slot frees up
            if (slot_free) begin
               out_in                 = '0;
               out_in.event_res       = sla_pkg::EV_LINE_DONE;
               out_in.line_valid      = 1'b1;
               out_in.line_char       = ram_q;
               out_in.line_length     = sla_pkg::LEN_W'(len_ff);
               out_in.last            = run_last;
               if (idx_ff == '0) begin
                  out_in.echo_valid      = cfg.echo_enable;
                  out_in.echo_char       = cfg.echo_enable ? sla_pkg::CH_LF : '0;
                  out_in.echo_cr_follows = cfg.echo_enable && cfg.newline_adds_cr;
               end
               out_vld_in = 1'b1;
               idx_in     = idx_ff + AW'(1);
               state_in   = run_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

   // line count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LINE_CHARS))
      else $error("line count beyond store depth");

   // the count is cleared for the whole replay of a line
   a_count_clear_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff == '0))
      else $error("line count not cleared during replay");

   // replay index stays below the captured length
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (CW'(idx_ff) < len_ff))
      else $error("replay index past line length");

   // a finished run returns to idle
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WAIT) && slot_free && run_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last char");

endmodule

### design/serial_line_assembler.sv
// ----------------------------------------------------------------------------
// serial_line_assembler
// Line editor for a received serial stream: stores, erases and reports
// control characters, and replays a finished line one char per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per beat (bit 7 ignored). rsp_* carries
//   result beats; rsp_tlast marks the final beat caused by one received byte.
//   csr_* sets echo, semicolon line end and cr after newline; write only idle.
// Latency and throughput:
//   A stored char, erase or control code gives one beat, visible the cycle
//   after it is taken; a new byte is taken every cycle while the receiver
//   keeps up. A line end with n stored chars gives n beats: each char is read
//   from the line store RAM, then loaded into the output register; the next
//   byte is taken after the last beat is loaded. An empty line gives one beat.
// Reset:
//   Clears the modes, the line count and the output valid flag. The line
//   store needs no clearing pass: only entries below the count are ever read.
// Receiver stall:
//   The result sits in the output register; the sequencer waits and the
//   input side stays not ready until the register frees up.
// ----------------------------------------------------------------------------
module serial_line_assembler #(
   parameter int LINE_CHARS = sla_pkg::LINE_CHARS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [0] echo_valid, [7:1] echo_char,
                                                       // [8] echo_cr_follows, [9] line_valid,
                                                       // [16:10] line_char, [23:17] line_length
   output logic [2:0]                     rsp_tuser,   // [2:0] event_res
   output logic                           rsp_tlast,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   sla_pkg::cfg_type cfg;
   sla_pkg::rsp_type rsp;

   sla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sla_core #(
      .LINE_CHARS (LINE_CHARS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rx_byte   (req_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result beat
   assign rsp_tdata = {rsp.line_length, rsp.line_char, rsp.line_valid,
                       rsp.echo_cr_follows, rsp.echo_char, rsp.echo_valid};
   assign rsp_tuser = rsp.event_res;
   assign rsp_tlast = rsp.last;

endmodule
